>>> rtl/core/gbu_pkg.sv
// ============================================================================
// gbu_pkg: shared types and constants of the glyph bitmap unpacker
// Register indexes, field widths and the control bundle that passes from
// the byte gatherer to the pixel serialiser.
// ============================================================================
package gbu_pkg;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 9;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GLYPH_WIDTH    = 3'd0,
    REG_GLYPH_HEIGHT   = 3'd1,
    REG_ROW_PAD_CODE   = 3'd2,
    REG_WORD_SIZE_CODE = 3'd3,
    REG_MSBYTE_FIRST   = 3'd4,
    REG_MSBIT_FIRST    = 3'd5
  } gbu_reg_t;

  // Glyph dimensions: 9-bit registers, saturated at this size
  localparam int          DIM_W         = 9;
  localparam logic [8:0]  GLYPH_DIM_MAX = 9'd256;

  // Pixel coordinates on the output
  localparam int COORD_W = 8;

  // Bytes per word or per row alignment, 1..8
  localparam int WS_W = 4;

  // Byte counter within a row: a row holds at most 32 bytes
  localparam int ROW_BYTE_W = 6;

  // Word launch bundle, gatherer to serialiser
  typedef struct packed {
    logic [DIM_W-1:0]   x0;         // column of the first pixel of the word
    logic [DIM_W-1:0]   last_x;     // column of the last pixel emitted
    logic [COORD_W-1:0] y;          // row of the word
    logic               glyph_end;  // last emitted pixel closes the glyph
    logic [WS_W-1:0]    ws;         // bytes in the word
    logic               msbyte;     // bytes within the word reversed
    logic               msbit;      // leftmost pixel is bit 7
  } gbu_launch_t;

endpackage

>>> rtl/core/gbu_ctrl.sv
// ============================================================================
// gbu_ctrl: configuration registers, byte gatherer and row bookkeeping
// Holds the word buffer and the byte/row counters and, on the byte that
// completes a word, hands the word and its pixel span to the serialiser.
// ============================================================================
module gbu_ctrl #(
  parameter int MAX_WORD_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gbu_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gbu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_accept,
  input  logic [7:0]                    in_byte,
  output logic                          launch_valid,
  output gbu_pkg::gbu_launch_t          launch,
  output logic [7:0]                    word_bytes [MAX_WORD_BYTES]
);

  localparam int BUF_AW = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
  localparam logic [gbu_pkg::WS_W-1:0] MWB_V = gbu_pkg::WS_W'(MAX_WORD_BYTES);

  // configuration
  logic [gbu_pkg::DIM_W-1:0] width_r,  width_nxt;
  logic [gbu_pkg::DIM_W-1:0] height_r, height_nxt;
  logic [1:0]                pad_code_r, pad_code_nxt;
  logic [1:0]                ws_code_r,  ws_code_nxt;
  logic                      msbyte_r,   msbyte_nxt;
  logic                      msbit_r,    msbit_nxt;
  logic                      cfg_hit;

  // counters
  logic [BUF_AW-1:0]                  biw_r, biw_nxt, biw_c;
  logic [gbu_pkg::ROW_BYTE_W-1:0]     bir_r, bir_nxt, bir_c, bir_inc;
  logic [gbu_pkg::COORD_W-1:0]        row_r, row_nxt, row_c;
  logic [gbu_pkg::DIM_W-1:0]          row_inc;

  logic [7:0] wbuf_r [MAX_WORD_BYTES];

  // derived geometry
  logic [gbu_pkg::DIM_W-1:0]      eff_w, eff_h, w_m1, h_m1;
  logic [gbu_pkg::WS_W-1:0]       pad_bytes, ws;
  logic [gbu_pkg::ROW_BYTE_W-1:0] bytes_w, pad_m1, rb, word_start;
  logic [gbu_pkg::DIM_W-1:0]      x0, x_end, last_x;
  logic                           active, done, emit, take;

  always_comb begin
    eff_w = (width_r  > gbu_pkg::GLYPH_DIM_MAX) ? gbu_pkg::GLYPH_DIM_MAX : width_r;
    eff_h = (height_r > gbu_pkg::GLYPH_DIM_MAX) ? gbu_pkg::GLYPH_DIM_MAX : height_r;
    w_m1  = eff_w - 9'd1;
    h_m1  = eff_h - 9'd1;
    active = (eff_w != '0) && (eff_h != '0);

    pad_bytes = gbu_pkg::WS_W'(1) << pad_code_r;
    ws        = gbu_pkg::WS_W'(1) << ws_code_r;
    if (ws > pad_bytes) ws = pad_bytes;
    if (ws > MWB_V)     ws = MWB_V;

    bytes_w = gbu_pkg::ROW_BYTE_W'((eff_w + 9'd7) >> 3);
    pad_m1  = gbu_pkg::ROW_BYTE_W'(pad_bytes) - 6'd1;
    rb      = (bytes_w + pad_m1) & ~pad_m1;

    // counters out of range after a register change start over
    biw_c = (gbu_pkg::WS_W'(biw_r) >= ws) ? '0 : biw_r;
    bir_c = (bir_r >= rb) ? '0 : bir_r;
    row_c = ({1'b0, row_r} >= eff_h) ? '0 : row_r;

    done       = (gbu_pkg::WS_W'(biw_c) + 4'd1) == ws;
    word_start = bir_c + 6'd1 - gbu_pkg::ROW_BYTE_W'(ws);
    x0         = {word_start, 3'b000};
    x_end      = x0 + gbu_pkg::DIM_W'({ws, 3'b000}) - 9'd1;
    emit       = x0 < eff_w;
    last_x     = (x_end <= w_m1) ? x_end : w_m1;

    take         = in_accept && active;
    launch_valid = take && done && emit;

    launch.x0        = x0;
    launch.last_x    = last_x;
    launch.y         = row_c;
    launch.glyph_end = ({1'b0, row_c} == h_m1) && (last_x == w_m1);
    launch.ws        = ws;
    launch.msbyte    = msbyte_r;
    launch.msbit     = msbit_r;
  end

  // the completing byte is merged in on its way past
  always_comb begin
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      word_bytes[i] = (BUF_AW'(i) == biw_c) ? in_byte : wbuf_r[i];
    end
  end

  // register writes
  always_comb begin
    width_nxt    = width_r;
    height_nxt   = height_r;
    pad_code_nxt = pad_code_r;
    ws_code_nxt  = ws_code_r;
    msbyte_nxt   = msbyte_r;
    msbit_nxt    = msbit_r;
    cfg_hit      = 1'b0;
    if (cfg_we) begin
      cfg_hit = 1'b1;
      case (gbu_pkg::gbu_reg_t'(cfg_addr))
        gbu_pkg::REG_GLYPH_WIDTH:    width_nxt    = cfg_wdata;
        gbu_pkg::REG_GLYPH_HEIGHT:   height_nxt   = cfg_wdata;
        gbu_pkg::REG_ROW_PAD_CODE:   pad_code_nxt = cfg_wdata[1:0];
        gbu_pkg::REG_WORD_SIZE_CODE: ws_code_nxt  = cfg_wdata[1:0];
        gbu_pkg::REG_MSBYTE_FIRST:   msbyte_nxt   = cfg_wdata[0];
        gbu_pkg::REG_MSBIT_FIRST:    msbit_nxt    = cfg_wdata[0];
        default:                     cfg_hit      = 1'b0;
      endcase
    end
  end

  // byte / row bookkeeping
  always_comb begin
    biw_nxt = biw_r;
    bir_nxt = bir_r;
    row_nxt = row_r;
    bir_inc = bir_c + 6'd1;
    row_inc = {1'b0, row_c} + 9'd1;
    if (cfg_hit) begin
      biw_nxt = '0;
      bir_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      biw_nxt = done ? '0 : BUF_AW'(gbu_pkg::WS_W'(biw_c) + 4'd1);
      if (bir_inc >= rb) begin
        biw_nxt = '0;
        bir_nxt = '0;
        row_nxt = (row_inc >= eff_h) ? '0 : row_inc[gbu_pkg::COORD_W-1:0];
      end else begin
        bir_nxt = bir_inc;
        row_nxt = row_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= '0;
      height_r   <= '0;
      pad_code_r <= '0;
      ws_code_r  <= '0;
      msbyte_r   <= 1'b0;
      msbit_r    <= 1'b0;
      biw_r      <= '0;
      bir_r      <= '0;
      row_r      <= '0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      pad_code_r <= pad_code_nxt;
      ws_code_r  <= ws_code_nxt;
      msbyte_r   <= msbyte_nxt;
      msbit_r    <= msbit_nxt;
      biw_r      <= biw_nxt;
      bir_r      <= bir_nxt;
      row_r      <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wbuf_r[biw_c] <= in_byte;
    end
  end

endmodule

>>> rtl/core/gbu_serial.sv
// ============================================================================
// gbu_serial: pixel serialiser
// Loads a finished word into a shift register in pixel order and emits
// one pixel per cycle through an output register unless out_ready stalls.
// ============================================================================
module gbu_serial #(
  parameter int MAX_WORD_BYTES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        launch_valid,
  input  gbu_pkg::gbu_launch_t        launch,
  input  logic [7:0]                  word_bytes [MAX_WORD_BYTES],
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gbu_pkg::COORD_W-1:0] out_x,
  output logic [gbu_pkg::COORD_W-1:0] out_y,
  output logic                        out_ink,
  output logic                        out_run_last,
  output logic                        out_glyph_last
);

  localparam int BUF_AW = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
  localparam int SR_W   = 8 * MAX_WORD_BYTES;
  localparam logic [gbu_pkg::WS_W-1:0] MWB_V = gbu_pkg::WS_W'(MAX_WORD_BYTES);

  logic                        busy_r, busy_nxt;
  logic [SR_W-1:0]             sr_r, sr_nxt, sr_load;
  logic [gbu_pkg::DIM_W-1:0]   x_r, x_nxt, last_x_r, last_x_nxt;
  logic [gbu_pkg::COORD_W-1:0] y_r, y_nxt;
  logic                        gend_r, gend_nxt;

  logic                        ov_r, ov_nxt;
  logic [gbu_pkg::COORD_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic                        oink_r, oink_nxt, orl_r, orl_nxt, ogl_r, ogl_nxt;

  logic advance, at_last;

  // word into pixel order: byte order by msbyte, bit order by msbit
  always_comb begin
    logic [gbu_pkg::WS_W-1:0] pos;
    logic [7:0]               byt;
    sr_load = '0;
    for (int k = 0; k < MAX_WORD_BYTES; k++) begin
      pos = launch.msbyte ? (launch.ws - 4'd1 - gbu_pkg::WS_W'(k)) : gbu_pkg::WS_W'(k);
      byt = (pos < MWB_V) ? word_bytes[pos[BUF_AW-1:0]] : 8'd0;
      for (int b = 0; b < 8; b++) begin
        sr_load[k*8 + b] = launch.msbit ? byt[7-b] : byt[b];
      end
    end
  end

  always_comb begin
    advance = busy_r && (!ov_r || out_ready);
    at_last = (x_r == last_x_r);

    busy_nxt   = busy_r;
    sr_nxt     = sr_r;
    x_nxt      = x_r;
    last_x_nxt = last_x_r;
    y_nxt      = y_r;
    gend_nxt   = gend_r;
    ov_nxt     = ov_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oink_nxt   = oink_r;
    orl_nxt    = orl_r;
    ogl_nxt    = ogl_r;

    if (launch_valid) begin
      busy_nxt   = 1'b1;
      sr_nxt     = sr_load;
      x_nxt      = launch.x0;
      last_x_nxt = launch.last_x;
      y_nxt      = launch.y;
      gend_nxt   = launch.glyph_end;
    end else if (advance) begin
      sr_nxt = sr_r >> 1;
      x_nxt  = x_r + 9'd1;
      if (at_last) busy_nxt = 1'b0;
    end

    if (advance) begin
      ov_nxt   = 1'b1;
      ox_nxt   = x_r[gbu_pkg::COORD_W-1:0];
      oy_nxt   = y_r;
      oink_nxt = sr_r[0];
      orl_nxt  = at_last;
      ogl_nxt  = at_last && gend_r;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r     <= sr_nxt;
    x_r      <= x_nxt;
    last_x_r <= last_x_nxt;
    y_r      <= y_nxt;
    gend_r   <= gend_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    oink_r   <= oink_nxt;
    orl_r    <= orl_nxt;
    ogl_r    <= ogl_nxt;
  end

  assign busy           = busy_r;
  assign out_valid      = ov_r;
  assign out_x          = ox_r;
  assign out_y          = oy_r;
  assign out_ink        = oink_r;
  assign out_run_last   = orl_r;
  assign out_glyph_last = ogl_r;

endmodule

>>> rtl/core/glyph_bitmap_unpacker.sv
// ============================================================================
// glyph_bitmap_unpacker: bitmap font glyph unpacker, top level
// Takes a glyph's bitmap bytes in file order and emits one ink bit per pixel
// with its column and row, row-major, skipping padding and columns past the
// glyph width.
// ============================================================================
//
//  channel  | direction | item                     | accepted when
//  ---------+-----------+--------------------------+----------------------------
//  in_*     | in        | one bitmap byte          | in_tvalid && in_tready
//  out_*    | out       | one pixel (x, y, ink)    | out_tvalid && out_tready
//  cfg_*    | in        | one register write       | cfg_we
//
//  A byte that does not complete a storage word goes into the word buffer.
//  The completing byte starts the serialiser: one pixel per cycle unless
//  out_tready stalls, up to 8 x word-bytes pixels per word.
//  in_tready is low while the serialiser shifts; the last pixel of a word
//  may wait in the output register while the next byte is taken.
//  rst_n (synchronous) clears config, counters, busy, out_tvalid; out_tready low stalls, nothing lost.
//
module glyph_bitmap_unpacker #(
  parameter int MAX_WORD_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input bytes
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  // pixels
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // [7:0] pixel_x, [15:8] pixel_y,
                                                     // [16] ink, [23:17] zero
  output logic                           out_tlast,  // run_last
  output logic [0:0]                     out_tuser,  // [0] glyph_last
  // configuration
  input  logic                           cfg_we,
  input  logic [gbu_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gbu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                        in_accept;
  logic                        launch_valid;
  gbu_pkg::gbu_launch_t        launch;
  logic [7:0]                  word_bytes [MAX_WORD_BYTES];
  logic                        busy;
  logic [gbu_pkg::COORD_W-1:0] px, py;
  logic                        ink, run_last, glyph_last;

  // one byte at a time: the serialiser owns the word until its last pixel
  assign in_tready = !busy;
  assign in_accept = in_tvalid && in_tready;

  // registers, counters, word buffer
  gbu_ctrl #(
    .MAX_WORD_BYTES (MAX_WORD_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_accept    (in_accept),
    .in_byte      (in_tdata),
    .launch_valid (launch_valid),
    .launch       (launch),
    .word_bytes   (word_bytes)
  );

  // bit-serial pixel emission
  gbu_serial #(
    .MAX_WORD_BYTES (MAX_WORD_BYTES)
  ) u_serial (
    .clk            (clk),
    .rst_n          (rst_n),
    .launch_valid   (launch_valid),
    .launch         (launch),
    .word_bytes     (word_bytes),
    .busy           (busy),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_x          (px),
    .out_y          (py),
    .out_ink        (ink),
    .out_run_last   (run_last),
    .out_glyph_last (glyph_last)
  );

  assign out_tdata = {7'd0, ink, py, px};
  assign out_tlast = run_last;
  assign out_tuser = glyph_last;

endmodule
